// ===== rtl/core/flow_color_wheel_coder_defines.svh =====
// Assertion helpers for the flow color-wheel coder
`ifndef FLOW_COLOR_WHEEL_CODER_DEFINES_SVH
`define FLOW_COLOR_WHEEL_CODER_DEFINES_SVH

// same-cycle implication
`define FCWC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FCWC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fcwc_pkg.sv =====
`default_nettype none
package fcwc_pkg;

   localparam int WHEEL_LEN = 55;
   localparam int ATAN_LEN  = 24;
   localparam logic CSR_INV_MAX_RADIUS = 1'b0;

   localparam logic [23:0] WHEEL [0:WHEEL_LEN-1] = '{
      24'hFF0000, 24'hFF1100, 24'hFF2200, 24'hFF3300, 24'hFF4400, 24'hFF5500,
      24'hFF6600, 24'hFF7700, 24'hFF8800, 24'hFF9900, 24'hFFAA00, 24'hFFBB00,
      24'hFFCC00, 24'hFFDD00, 24'hFFEE00,
      24'hFFFF00, 24'hD5FF00, 24'hAAFF00, 24'h80FF00, 24'h55FF00, 24'h2BFF00,
      24'h00FF00, 24'h00FF3F, 24'h00FF7F, 24'h00FFBF,
      24'h00FFFF, 24'h00E8FF, 24'h00D1FF, 24'h00BAFF, 24'h00A3FF, 24'h008CFF,
      24'h0074FF, 24'h005DFF, 24'h0046FF, 24'h002FFF, 24'h0018FF,
      24'h0000FF, 24'h1300FF, 24'h2700FF, 24'h3A00FF, 24'h4E00FF, 24'h6200FF,
      24'h7500FF, 24'h8900FF, 24'h9C00FF, 24'hB000FF, 24'hC400FF, 24'hD700FF,
      24'hEB00FF,
      24'hFF00FF, 24'hFF00D5, 24'hFF00AA, 24'hFF0080, 24'hFF0055, 24'hFF002B
   };

   localparam logic [31:0] ATAN [0:ATAN_LEN-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
      32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
   };

   typedef struct packed {
      logic        in_unit;
      logic [16:0] rad16;
   } radius_type;

   typedef struct packed {
      logic [5:0]  k0;
      logic [15:0] frac;
   } wheel_pos_type;

   typedef struct packed {
      logic          fv;
      radius_type    rad;
      wheel_pos_type pos;
   } shade_in_type;

endpackage
`default_nettype wire

// ===== rtl/core/flow_color_wheel_coder.sv =====
// The delay is set by the longer of the one-bit-per-stage square root and the CORDIC stages,
// followed by the shading registers.
// Throughput: one transaction per cycle; the whole pipeline holds while the output stalls.
// Reset: synchronous, active high; clears the valid bits and loads the scale with 16384.
`default_nettype none
`include "flow_color_wheel_coder_defines.svh"
module flow_color_wheel_coder #(
   parameter int CORDIC_STAGES  = 16,
   parameter int FLOW_FRAC_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // flow_x, flow_y
   input  wire logic        req_tuser,   // flow_valid
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // red, green, blue
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int NA = (CORDIC_STAGES < fcwc_pkg::ATAN_LEN) ?
                       CORDIC_STAGES : fcwc_pkg::ATAN_LEN;
   localparam int LR = FLOW_FRAC_BITS + 19;
   localparam int LA = NA + 2;
   localparam int LJ = (LR > LA) ? LR : LA;
   localparam int LT = LJ + 2;
   localparam int DR = LJ - LR;
   localparam int DA = LJ - LA;

   logic [15:0]   inv_ff;
   logic [LT-1:0] vld_ff, vld_in;
   logic [LJ-1:0] fv_ff;
   logic          en, csr_wr;
   fcwc_pkg::radius_type    rad_q [0:DR];
   fcwc_pkg::wheel_pos_type pos_q [0:DA];
   fcwc_pkg::shade_in_type  shade_in;
   logic [7:0] red, green, blue;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == fcwc_pkg::CSR_INV_MAX_RADIUS) ? {16'd0, inv_ff} : 32'd0;
   assign vld_in     = {vld_ff[LT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 16'd16384;
         vld_ff <= '0;
      end else begin
         if (csr_wr && csr_paddr[2] == fcwc_pkg::CSR_INV_MAX_RADIUS) inv_ff <= csr_pwdata[15:0];
         if (en) vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) fv_ff <= {fv_ff[LJ-2:0], req_tuser};
   end

   fcwc_radius #(.FLOW_FRAC_BITS(FLOW_FRAC_BITS)) u_radius (
      .clock  (clock),
      .en     (en),
      .flow_x (req_tdata[15:0]),
      .flow_y (req_tdata[31:16]),
      .inv    (inv_ff),
      .rad    (rad_q[0])
   );

   fcwc_angle #(.CORDIC_STAGES(CORDIC_STAGES)) u_angle (
      .clock  (clock),
      .en     (en),
      .flow_x (req_tdata[15:0]),
      .flow_y (req_tdata[31:16]),
      .pos    (pos_q[0])
   );

   for (genvar k = 1; k <= DR; k++) begin : g_rad_dly
      always_ff @(posedge clock) begin
         if (en) rad_q[k] <= rad_q[k-1];
      end
   end

   for (genvar k = 1; k <= DA; k++) begin : g_pos_dly
      always_ff @(posedge clock) begin
         if (en) pos_q[k] <= pos_q[k-1];
      end
   end

   always_comb begin
      shade_in.fv  = fv_ff[LJ-1];
      shade_in.rad = rad_q[DR];
      shade_in.pos = pos_q[DA];
   end

   fcwc_shade u_shade (
      .clock (clock),
      .en    (en),
      .in_s  (shade_in),
      .red   (red),
      .green (green),
      .blue  (blue)
   );

   assign rsp_tvalid = vld_ff[LT-1];
   assign rsp_tdata  = {blue, green, red};

   `FCWC_ASSERT_NEXT(a_csr_write, csr_wr && csr_paddr[2] == fcwc_pkg::CSR_INV_MAX_RADIUS,
      inv_ff == $past(csr_pwdata[15:0]), "scale register not written")
   `FCWC_ASSERT_NOW(a_rad_bound, vld_ff[LR-1] && rad_q[0].in_unit,
      rad_q[0].rad16 <= 17'h10000, "radius beyond one inside unit circle")

endmodule
`default_nettype wire

// ===== rtl/core/fcwc_radius.sv =====
`default_nettype none
module fcwc_radius #(
   parameter int FLOW_FRAC_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic signed [15:0]    flow_x,
   input  wire logic signed [15:0]    flow_y,
   input  wire logic [15:0]           inv,
   output fcwc_pkg::radius_type       rad
);
   localparam int RW    = FLOW_FRAC_BITS + 15;
   localparam int TW    = 2 * RW + 1;
   localparam int SHIFT = FLOW_FRAC_BITS - 2;
   localparam logic [62:0] ONE_SQ = 63'd1 << (2 * (FLOW_FRAC_BITS + 14));

   logic [16:0] ax_ff, ay_ff, ax_in, ay_in;
   logic [32:0] prod_x, prod_y;
   logic [30:0] px_ff, py_ff;
   logic [61:0] sqx_ff, sqy_ff;
   logic [62:0] sum;
   logic        inside_in;
   logic [TW-1:0] rem_ff  [0:RW];
   logic [TW-1:0] root_ff [0:RW];
   logic          inside_ff [0:RW];
   logic [TW-1:0] rem_in  [1:RW];
   logic [TW-1:0] root_in [1:RW];

   always_comb begin
      ax_in  = flow_x[15] ? (17'd0 - {flow_x[15], flow_x}) : {1'b0, flow_x};
      ay_in  = flow_y[15] ? (17'd0 - {flow_y[15], flow_y}) : {1'b0, flow_y};
      prod_x = {16'd0, ax_ff} * {17'd0, inv};
      prod_y = {16'd0, ay_ff} * {17'd0, inv};
      sum    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      inside_in = sum <= ONE_SQ;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         px_ff  <= prod_x[30:0];
         py_ff  <= prod_y[30:0];
         sqx_ff <= {31'd0, px_ff} * {31'd0, px_ff};
         sqy_ff <= {31'd0, py_ff} * {31'd0, py_ff};
         inside_ff[0] <= inside_in;
         rem_ff[0]    <= inside_in ? sum[TW-1:0] : ONE_SQ[TW-1:0];
         root_ff[0]   <= '0;
      end
   end

   // one root bit per stage, msb first
   for (genvar s = 0; s < RW; s++) begin : g_sqrt
      localparam int J = RW - 1 - s;
      logic [TW-1:0] test;
      always_comb begin
         test = (root_ff[s] << (J + 1)) + (TW'(1) << (2 * J));
         if (rem_ff[s] >= test) begin
            rem_in[s+1]  = rem_ff[s] - test;
            root_in[s+1] = root_ff[s] | (TW'(1) << J);
         end else begin
            rem_in[s+1]  = rem_ff[s];
            root_in[s+1] = root_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1]    <= rem_in[s+1];
            root_ff[s+1]   <= root_in[s+1];
            inside_ff[s+1] <= inside_ff[s];
         end
      end
   end

   assign rad.in_unit = inside_ff[RW];
   assign rad.rad16   = root_ff[RW][SHIFT +: 17];

endmodule
`default_nettype wire

// ===== rtl/core/fcwc_angle.sv =====
`default_nettype none
module fcwc_angle #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic signed [15:0]    flow_x,
   input  wire logic signed [15:0]    flow_y,
   output fcwc_pkg::wheel_pos_type    pos
);
   localparam int N  = (CORDIC_STAGES < fcwc_pkg::ATAN_LEN) ?
                       CORDIC_STAGES : fcwc_pkg::ATAN_LEN;
   localparam int XW = 36;

   logic signed [XW-1:0] x_ff [0:N];
   logic signed [XW-1:0] y_ff [0:N];
   logic [31:0]          z_ff [0:N];
   logic                 spec_ff [0:N];
   logic signed [XW-1:0] xs, ys, x0_in, y0_in;
   logic [31:0]          z0_in;
   logic [31:0]          u;
   logic [37:0]          prod;
   fcwc_pkg::wheel_pos_type pos_ff, pos_in;

   always_comb begin
      xs = (XW'(0) - {{(XW-16){flow_x[15]}}, flow_x}) <<< 16;
      ys = (XW'(0) - {{(XW-16){flow_y[15]}}, flow_y}) <<< 16;
      x0_in = xs;
      y0_in = ys;
      z0_in = 32'h0000_0000;
      if (xs < 0) begin
         if (ys >= 0) begin
            x0_in = ys;
            y0_in = -xs;
            z0_in = 32'h4000_0000;
         end else begin
            x0_in = -ys;
            y0_in = xs;
            z0_in = 32'hC000_0000;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         // negated flow on the negative real axis
         spec_ff[0] <= (flow_y == 16'sd0) && !flow_x[15] && (flow_x != 16'sd0);
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (en) begin
            spec_ff[i+1] <= spec_ff[i];
            if (!y_ff[i][XW-1]) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + fcwc_pkg::ATAN[i];
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - fcwc_pkg::ATAN[i];
            end
         end
      end
   end

   always_comb begin
      u    = (spec_ff[N] ? 32'h8000_0000 : z_ff[N]) + 32'h8000_0000;
      prod = {6'd0, u} * 38'd54;
      pos_in.k0   = (prod[37:32] > 6'd53) ? 6'd53 : prod[37:32];
      pos_in.frac = prod[31:16];
   end

   always_ff @(posedge clock) begin
      if (en) pos_ff <= pos_in;
   end

   assign pos = pos_ff;

endmodule
`default_nettype wire

// ===== rtl/core/fcwc_shade.sv =====
`default_nettype none
module fcwc_shade (
   input  wire logic                clock,
   input  wire logic                en,
   input  fcwc_pkg::shade_in_type   in_s,
   output logic [7:0]               red,
   output logic [7:0]               green,
   output logic [7:0]               blue
);
   logic [23:0] c_ff [0:2];
   logic [23:0] c_in [0:2];
   logic [7:0]  v_ff [0:2];
   logic [7:0]  v_in [0:2];
   logic        fv_ff, inside_ff;
   logic [16:0] rad16_ff;
   logic [23:0] col0, col1;

   always_comb begin
      col0 = fcwc_pkg::WHEEL[in_s.pos.k0];
      col1 = fcwc_pkg::WHEEL[in_s.pos.k0 + 6'd1];
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_ch
      logic [24:0] c_sum;
      logic [23:0] diff;
      logic [40:0] p;
      logic [39:0] lit;
      logic [25:0] dim;
      always_comb begin
         c_sum = {8'd0, 17'd65536 - {1'b0, in_s.pos.frac}} * {17'd0, col0[(2-ch)*8 +: 8]}
               + {9'd0, in_s.pos.frac} * {17'd0, col1[(2-ch)*8 +: 8]};
         c_in[ch] = c_sum[23:0];
         diff = 24'hFF0000 - c_ff[ch];
         p    = {24'd0, rad16_ff} * {17'd0, diff};
         lit  = 40'hFF_0000_0000 - p[39:0];
         dim  = 26'd3 * {2'd0, c_ff[ch]};
         if (!fv_ff) v_in[ch] = 8'd0;
         else if (inside_ff) v_in[ch] = lit[39:32];
         else v_in[ch] = dim[25:18];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            c_ff[ch] <= c_in[ch];
            v_ff[ch] <= v_in[ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fv_ff     <= in_s.fv;
         inside_ff <= in_s.rad.in_unit;
         rad16_ff  <= in_s.rad.rad16;
      end
   end

   assign red   = v_ff[0];
   assign green = v_ff[1];
   assign blue  = v_ff[2];

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none

class pixel_scoreboard;
   logic [23:0] rgb_q[$];
   logic [15:0] inv_radius;
   int errors;
   int checked;

   function new();
      inv_radius = 16'd16384;
      errors = 0;
      checked = 0;
   endfunction

   static function logic [31:0] flow_angle(logic signed [63:0] x, logic signed [63:0] y);
      logic [31:0] z;
      logic signed [63:0] t, dx, dy;
      z = 32'h0;
      if (y == 0 && x < 0) return 32'h8000_0000;
      x = x <<< 16;
      y = y <<< 16;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 32'h4000_0000;
         end else begin
            x = -y; y = t; z = 32'hC000_0000;
         end
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + fcwc_pkg::ATAN[i];
         end else begin
            x = x - dx; y = y + dy; z = z - fcwc_pkg::ATAN[i];
         end
      end
      return z;
   endfunction

   static function logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'h1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else res = res >> 1;
         b = b >> 2;
      end
      return res;
   endfunction

   function logic [23:0] shade(logic [15:0] fx, logic [15:0] fy, logic fv);
      logic signed [63:0] sx, sy;
      logic [63:0] ax, ay, px, py, sum, rad, prod, f, c, v, w;
      logic [31:0] u;
      logic [5:0] k0;
      logic [23:0] c0, c1, rgb;
      logic in_unit;
      if (!fv) return 24'h0;
      sx = $signed(fx);
      sy = $signed(fy);
      ax = sx < 0 ? -sx : sx;
      ay = sy < 0 ? -sy : sy;
      px = ax * inv_radius;
      py = ay * inv_radius;
      sum = px * px + py * py;
      in_unit = sum <= (64'h1 << 44);
      rad = in_unit ? int_sqrt(sum) >> 6 : 0;
      u = flow_angle(-sx, -sy) + 32'h8000_0000;
      prod = u * 64'd54;
      k0 = (prod >> 32) > 53 ? 6'd53 : 6'(prod >> 32);
      f = (prod >> 16) & 64'hFFFF;
      c0 = fcwc_pkg::WHEEL[k0];
      c1 = fcwc_pkg::WHEEL[k0 + 1];
      w = 64'd255 << 16;
      for (int b = 0; b < 3; b++) begin
         c = (65536 - f) * c0[23 - 8 * b -: 8] + f * c1[23 - 8 * b -: 8];
         v = in_unit ? ((w << 16) - rad * (w - c)) >> 32 : (3 * c) >> 18;
         rgb[8 * b +: 8] = v[7:0];
      end
      return rgb;
   endfunction

   function void note_flow(logic [31:0] data, logic fv);
      rgb_q.push_back(shade(data[15:0], data[31:16], fv));
   endfunction

   function void check_pixel(logic [23:0] got);
      logic [23:0] exp_rgb;
      if (rgb_q.size() == 0) begin
         $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      exp_rgb = rgb_q.pop_front();
      checked++;
      for (int b = 0; b < 3; b++)
         if (exp_rgb[8 * b +: 8] !== got[8 * b +: 8]) begin
            $display("%0t: channel %0d mismatch, expected %0d, actual %0d",
               $time, b, exp_rgb[8 * b +: 8], got[8 * b +: 8]);
            errors++;
         end
   endfunction
endclass

module testbench;
   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tuser = 0;
   logic [31:0] req_tdata = 0;
   logic req_tready;
   logic rsp_tvalid, rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0, csr_prdata;
   logic csr_pready;

   pixel_scoreboard sb = new();
   int idle_cycles = 0;
   int hold_off = 0;
   int sent = 0;

   always #10 clock = ~clock;

   flow_color_wheel_coder u_dut (.*);

   task automatic write_scale(logic [15:0] val);
      @(negedge clock);
      csr_psel = 1; csr_pwrite = 1; csr_paddr = {fcwc_pkg::CSR_INV_MAX_RADIUS, 2'b00};
      csr_pwdata = {16'd0, val};
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      sb.inv_radius = val;
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
   endtask

   task automatic send_flow(logic [15:0] fx, logic [15:0] fy, logic fv, bit gaps);
      int g;
      g = gaps ? $urandom_range(0, 16) : 0;
      if ($urandom_range(0, 3) == 0) g = 0;
      repeat (g) @(negedge clock);
      req_tvalid = 1; req_tdata = {fy, fx}; req_tuser = fv;
      do @(posedge clock); while (!req_tready);
      sb.note_flow({fy, fx}, fv);
      sent++;
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic drain();
      while (sb.rgb_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_flow(int n);
      logic [15:0] fx, fy;
      int m;
      for (int i = 0; i < n; i++) begin
         m = $urandom_range(0, 9);
         fx = 16'($urandom); fy = 16'($urandom);
         if (m < 5) begin
            fx = 16'($signed(fx) >>> $urandom_range(0, 14));
            fy = 16'($signed(fy) >>> $urandom_range(0, 14));
         end else if (m == 5) fy = 0;
         else if (m == 6) fx = 0;
         send_flow(fx, fy, $urandom_range(0, 7) != 0, 1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : receiver
      int g;
      @(negedge clock);
      while (1) begin
         if (hold_off > 0) begin
            rsp_tready = 0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end
         g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         if ($urandom_range(0, 2) == 0) g = 0;
         rsp_tready = g == 0;
         if (g != 0) begin
            repeat (g) @(negedge clock);
            rsp_tready = 1;
         end
         @(negedge clock);
      end
   end

   initial begin
      logic [15:0] scales[6];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      send_flow(16'h7FFF, 16'h7FFF, 1, 0);
      send_flow(16'h8000, 16'h8000, 1, 0);
      send_flow(16'h7FFF, 16'h8000, 1, 0);
      send_flow(16'h8000, 16'h7FFF, 1, 0);
      send_flow(16'h0100, 16'h0000, 1, 0);
      send_flow(16'hFF00, 16'h0000, 1, 0);
      send_flow(16'h0000, 16'h0100, 1, 0);
      send_flow(16'h0000, 16'hFF00, 1, 0);
      send_flow(16'h0000, 16'h0000, 1, 0);
      send_flow(16'h00B5, 16'h00B5, 1, 0);
      send_flow(16'h0080, 16'hFF80, 1, 0);
      send_flow(16'h1234, 16'h5678, 0, 0);
      send_flow(16'hFFFF, 16'hFFFF, 0, 0);
      send_flow(16'h0001, 16'hFFFF, 1, 0);
      send_flow(16'hFFFF, 16'h0000, 1, 0);
      drain();
      write_scale(16'd0);
      send_flow(16'h7FFF, 16'h1234, 1, 0);
      send_flow(16'h8000, 16'h0000, 1, 0);
      drain();
      scales = '{16'hFFFF, 16'd1, 16'd64, 16'd1024, 16'd16384, 16'd4096};
      foreach (scales[s]) begin
         write_scale(scales[s]);
         if (s == 2) begin
            hold_off = 300;
            random_flow(120);
         end
         random_flow(290);
         drain();
      end
      $display("Covered %0d flow transactions over 7 scale settings incl. 0 and 65535,", sent);
      $display("with random gaps, output stalls and one long back-pressure stretch.");
      if (sb.errors == 0 && sb.rgb_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
